// File: rtl/pal_pkg.sv
// Package for the positional array list: list depth, field widths and codes.
// Used by pal_cell and positional_array_list. Depends on nothing else.
`default_nettype none

package pal_pkg;

  // List geometry and field widths.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  // Operation codes carried by the mode field.
  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_INVALID   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  // Command given to one cell of the chain in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DUMP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/pal_cell.sv
// One cell of the list chain: holds a single entry and compares it with a key.
// Depends on pal_pkg for widths and the cell command type.
`default_nettype none

module pal_cell
  import pal_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] load_value,
  input  wire logic signed [DATA_W-1:0] lower_value,
  input  wire logic signed [DATA_W-1:0] upper_value,
  input  wire logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0]      value,
  output logic                          match
);

  // Entry register: take a new value, a neighbour's value, or keep its own.
  always_ff @(posedge clk) begin
    case (cmd)
      CELL_LOAD:       value <= load_value;
      CELL_SHIFT_UP:   value <= lower_value;
      CELL_SHIFT_DOWN: value <= upper_value;
      default:         value <= value;
    endcase
  end

  // Equality compare for search.
  assign match = (value == key);

endmodule

`default_nettype wire

// File: rtl/positional_array_list.sv
// Positional array list: clear, insert, delete and other single-result modes
// load the output register, one item per cycle while it is not stalled; a
// search registers the cell compares, then loads the priority-encoded result;
// a dump gives one entry per cycle while the output is not stalled, and neither
// takes a new item until its last result is loaded. Reset clears the count,
// sequencer and output valid, not entry cells, which hold nothing until written.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               mode,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] item_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    status,
  output logic [IDX_W-1:0]              found_index,
  output logic signed [DATA_W-1:0]      entry_value,
  output logic [CNT_W-1:0]              entry_count,
  output logic                          last
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] dump_idx;
  logic [DEPTH-1:0] match_vec;

  logic accept;
  logic out_free;
  logic search_load;
  logic dump_load;
  logic dump_last;
  logic ins_go;
  logic del_go;
  logic defer_result;

  cell_cmd_t                cell_cmd   [DEPTH];
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]         cell_match;

  status_t          imm_status;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  // Handshake decode.
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  // A search or a dump with entries never loads the output at acceptance.
  assign defer_result = (mode == MODE_SEARCH) || ((mode == MODE_DUMP) && (count != '0));

  // Insert (not full) and delete proceed only when the position is in range.
  assign ins_go = accept && (mode == MODE_INSERT) && (count < CNT_W'(DEPTH))
                  && (position <= count);
  assign del_go = accept && (mode == MODE_DELETE) && (position < count);

  // Per-cell commands: cells above the insert point move up, cells from the
  // delete point onwards move down.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_cmd[i] = CELL_HOLD;
      if (ins_go) begin
        if (POS_W'(i) > position) begin
          cell_cmd[i] = CELL_SHIFT_UP;
        end else if (POS_W'(i) == position) begin
          cell_cmd[i] = CELL_LOAD;
        end
      end else if (del_go) begin
        if (POS_W'(i) >= position) begin
          cell_cmd[i] = CELL_SHIFT_DOWN;
        end
      end
    end
  end

  // The chain of cells, each wired to its two neighbours.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;

    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_value[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_value[g+1];
    end

    pal_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd[g]),
      .load_value  (item_value),
      .lower_value (lower),
      .upper_value (upper),
      .key         (item_value),
      .value       (cell_value[g]),
      .match       (cell_match[g])
    );
  end

  // Count update and the status of single-result operations.
  always_comb begin
    count_next = count;
    imm_status = STATUS_OK;
    case (mode)
      MODE_CLEAR: begin
        count_next = '0;
      end
      MODE_INSERT: begin
        if (count >= CNT_W'(DEPTH)) begin
          imm_status = STATUS_FULL;
        end else if (position > count) begin
          imm_status = STATUS_INVALID;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (position >= count) begin
          imm_status = STATUS_INVALID;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      MODE_DUMP: begin
        if (count == '0) begin
          imm_status = STATUS_EMPTY;
        end
      end
      default: begin
        imm_status = STATUS_OK;
      end
    endcase
  end

  // Lowest matching index from the registered match vector.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign dump_last = (CNT_W'(dump_idx) + CNT_W'(1)) == count;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_SEARCH)) begin
          state_next = ST_SEARCH;
        end else if (accept && (mode == MODE_DUMP) && (count != '0)) begin
          state_next = ST_DUMP;
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free && dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall    = 1'b1;
    search_load = 1'b0;
    dump_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = !out_free;
      end
      ST_SEARCH: begin
        search_load = out_free;
      end
      ST_DUMP: begin
        dump_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dump_idx <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count    <= count_next;
        dump_idx <= '0;
      end else if (dump_load) begin
        dump_idx <= dump_idx + IDX_W'(1);
      end
    end
  end

  // Match vector for search, limited to entries below the count.
  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_SEARCH)) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= cell_match[i] && (CNT_W'(i) < count);
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !defer_result) || search_load || dump_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if ((mode == MODE_SEARCH) || ((mode == MODE_DUMP) && (count != '0))) begin
        // The result of this transfer follows from the sequencer.
        status <= status;
      end else begin
        status      <= imm_status;
        found_index <= '0;
        entry_value <= '0;
        entry_count <= count_next;
        last        <= 1'b1;
      end
    end else if (search_load) begin
      status      <= hit ? STATUS_OK : STATUS_NOT_FOUND;
      found_index <= hit_idx;
      entry_value <= '0;
      entry_count <= count;
      last        <= 1'b1;
    end else if (dump_load) begin
      status      <= STATUS_OK;
      found_index <= dump_idx;
      entry_value <= cell_value[dump_idx];
      entry_count <= count;
      last        <= dump_last;
    end
  end

  // Checks on the list logic.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("entry count exceeds the list depth");

  assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_INSERT) && (count == CNT_W'(DEPTH))) |=> (count == CNT_W'(DEPTH)))
    else $error("insert on a full list changed the count");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> ((count != '0) && (CNT_W'(dump_idx) < count)))
    else $error("dump index outside the stored entries");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !defer_result) |=> (out_valid && last))
    else $error("single-result transfer did not reach the output register");

endmodule

`default_nettype wire
